// File: rtl/hcbp_pkg.sv
// Shared types and constants of the Huffman code bit packer.
package hcbp_pkg;

	localparam int BYTE_W           = 8;
	localparam int CODE_W           = 16;
	localparam int LEN_W            = 5;
	localparam int PAD_W            = 4;
	localparam int SYMBOL_COUNT_DEF = 256;
	localparam int MAX_CODE_LEN_DEF = 16;

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_ENCODE = 2'd1,
		KIND_FLUSH  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [7:0]        symbol;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_length;
		logic [PAD_W-1:0]  pad_shift;
	} sym_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
	} byte_item_t;

	typedef struct packed {
		logic              valid;
		logic              flush;
		logic [PAD_W-1:0]  pad;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} stage_t;

endpackage

// File: rtl/hcbp_table.sv
// Code table memory and first pipeline stage with the looked-up code.
module hcbp_table #(
	parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hcbp_pkg::sym_item_t item,
	input  logic                accept,
	input  logic                advance,
	output hcbp_pkg::stage_t    stage
);
	import hcbp_pkg::*;

	localparam int IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int LEN_LIM = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

	logic [CODE_W+LEN_W-1:0] mem [SYMBOL_COUNT];
	logic [CODE_W+LEN_W-1:0] entry_s1;
	logic                    valid_s1;
	logic                    flush_s1;
	logic [PAD_W-1:0]        pad_s1;
	logic                    in_range;
	logic [IDX_W-1:0]        idx;
	logic [LEN_W-1:0]        len_c;
	logic [CODE_W-1:0]       code_m;

	assign in_range = {1'b0, item.symbol} < 9'(SYMBOL_COUNT);
	assign idx      = item.symbol[IDX_W-1:0];
	assign len_c    = (item.code_length > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM) : item.code_length;
	assign code_m   = item.code_bits & ~({CODE_W{1'b1}} << len_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (item.kind == KIND_FLUSH) || ((item.kind == KIND_ENCODE) && in_range);
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flush_s1 <= (item.kind == KIND_FLUSH);
			pad_s1   <= item.pad_shift;
			entry_s1 <= mem[idx];
			if ((item.kind == KIND_LOAD) && in_range) begin
				mem[idx] <= {code_m, len_c};
			end
		end
	end

	assign stage.valid = valid_s1;
	assign stage.flush = flush_s1;
	assign stage.pad   = pad_s1;
	assign stage.code  = entry_s1[CODE_W+LEN_W-1:LEN_W];
	assign stage.len   = entry_s1[LEN_W-1:0];

endmodule

// File: rtl/hcbp_packer.sv
// Bit accumulator, byte packing and the output byte queue.
module hcbp_packer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hcbp_pkg::stage_t     stage,
	output logic                 take,
	output logic                 out_valid,
	input  logic                 out_stall,
	output hcbp_pkg::byte_item_t out_item
);
	import hcbp_pkg::*;

	localparam int V_W = CODE_W + BYTE_W - 1;

	logic [BYTE_W-2:0]   acc_q;
	logic [2:0]          held_q;
	logic [2*BYTE_W-1:0] queue_q;
	logic [1:0]          cnt_q;
	logic                out_accept;
	logic                advance;
	logic [V_W-1:0]      v;
	logic [LEN_W-1:0]    total;
	logic [LEN_W-1:0]    sh;
	logic [V_W:0]        aligned;
	logic [15:0]         flush_w;

	assign out_accept = (cnt_q != 2'd0) && !out_stall;
	assign take       = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_accept);
	assign advance    = stage.valid && take;

	always_comb begin
		v       = (V_W'(acc_q) << stage.len) | V_W'(stage.code);
		total   = LEN_W'(held_q) + stage.len;
		sh      = LEN_W'(V_W + 1) - total;
		aligned = {1'b0, v} << sh;
		flush_w = {9'b0, acc_q} << stage.pad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			held_q <= '0;
			cnt_q  <= '0;
		end else if (advance) begin
			if (stage.flush) begin
				cnt_q  <= (held_q != 3'd0) ? 2'd1 : 2'd0;
				acc_q  <= '0;
				held_q <= '0;
			end else begin
				cnt_q  <= total[4:3];
				held_q <= total[2:0];
				acc_q  <= v[BYTE_W-2:0] & ~({(BYTE_W-1){1'b1}} << total[2:0]);
			end
		end else if (out_accept) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (stage.flush) begin
				queue_q <= {flush_w[BYTE_W-1:0], {BYTE_W{1'b0}}};
			end else begin
				queue_q <= aligned[V_W -: 2*BYTE_W];
			end
		end else if (out_accept) begin
			queue_q <= queue_q << BYTE_W;
		end
	end

	assign out_valid         = (cnt_q != 2'd0);
	assign out_item.out_byte = queue_q[2*BYTE_W-1:BYTE_W];
	assign out_item.last     = (cnt_q == 2'd1);

endmodule

// File: rtl/huffman_code_bit_packer.sv
// Top level of the Huffman code bit packer: code table, packing stage and output queue.
// Each item is registered with its code table lookup, then packed into the held bits
// when the stage advances, and its bytes leave the output port one per cycle while
// byte_stall is low, MSB first, with last on the final byte of the item. The block
// takes one item per cycle unless sym_stall is high; an encode item that completes
// two bytes holds the next item in the stage until its final byte is taken. Loads
// write the code table on acceptance and are visible to an encode item taken in the
// next cycle.
module huffman_code_bit_packer #(
	parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sym_valid,
	output logic                 sym_stall,
	input  hcbp_pkg::sym_item_t  sym_item,
	output logic                 byte_valid,
	input  logic                 byte_stall,
	output hcbp_pkg::byte_item_t byte_item
);
	import hcbp_pkg::*;

	stage_t stage;
	logic   take;
	logic   advance;
	logic   accept;

	assign advance   = stage.valid && take;
	assign sym_stall = stage.valid && !take;
	assign accept    = sym_valid && !sym_stall;

	hcbp_table #(
		.SYMBOL_COUNT (SYMBOL_COUNT),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (sym_item),
		.accept  (accept),
		.advance (advance),
		.stage   (stage)
	);

	hcbp_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage     (stage),
		.take      (take),
		.out_valid (byte_valid),
		.out_stall (byte_stall),
		.out_item  (byte_item)
	);

	a_no_advance_over_two_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> !(byte_valid && !byte_item.last))
		else $error("Stage advanced while two bytes were still queued.");

	a_load_leaves_stage_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (sym_item.kind == KIND_LOAD)) |=> !stage.valid)
		else $error("A load item entered the packing stage.");

	a_output_follows_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(byte_valid) |-> $past(advance))
		else $error("Output became valid without a stage advance.");

endmodule

// File: tb/tb_huffman_code_bit_packer.sv
// Self-checking testbench of the Huffman code bit packer: random handshakes, predicted bytes.
module tb_huffman_code_bit_packer;
	timeunit 1ns;
	timeprecision 1ps;

	import hcbp_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_ITEMS = 390;

	logic       clk;
	logic       arst_n;
	logic       sym_valid = 1'b0;
	logic       sym_stall;
	sym_item_t  sym_item = '0;
	logic       byte_valid;
	logic       byte_stall = 1'b0;
	byte_item_t byte_item;

	huffman_code_bit_packer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym_stall (sym_stall),
		.sym_item  (sym_item),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item (byte_item)
	);

	sym_item_t  symbols_to_send[$];
	byte_item_t packed_bytes_due[$];
	bit         entry_loaded[256];
	logic [7:0] loaded_symbols[$];

	logic [CODE_W-1:0] table_code[256];
	logic [LEN_W-1:0]  table_len[256];
	logic [7:0]        held_bits;
	logic [2:0]        held_count;

	int  symbols_queued = 0;
	int  symbols_taken = 0;
	int  mismatches = 0;
	int  idle_cycles = 0;
	int  send_gap = 0;
	int  send_quiet = 0;
	int  take_hold = 0;
	int  take_quiet = 0;
	bit  sym_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] low_ones(int n);
		return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
	endfunction

	// Mostly random waits, with occasional runs of back-to-back items.
	function automatic int idle_draw(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			quiet = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	task automatic report_mismatch(string what);
		$display("ERROR at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic pack_item(sym_item_t it);
		int         len;
		int         total;
		logic [31:0] acc;
		byte_item_t b;
		int         n;
		case (it.kind)
			KIND_LOAD: begin
				len = (it.code_length > CODE_W) ? CODE_W : it.code_length;
				table_len[it.symbol] = LEN_W'(len);
				table_code[it.symbol] = CODE_W'(it.code_bits & low_ones(len));
			end
			KIND_ENCODE: begin
				len = table_len[it.symbol];
				acc = ({24'd0, held_bits} << len) | {16'd0, table_code[it.symbol]};
				total = held_count + len;
				n = 0;
				while (total >= 8) begin
					total -= 8;
					b.out_byte = 8'(acc >> total);
					b.last = 1'b0;
					packed_bytes_due.push_back(b);
					n++;
				end
				if (n > 0)
					packed_bytes_due[$].last = 1'b1;
				held_count = 3'(total);
				held_bits = 8'(acc & low_ones(total));
			end
			KIND_FLUSH: begin
				if (held_count != 0) begin
					b.out_byte = 8'(({24'd0, held_bits} << it.pad_shift) & 32'hFF);
					b.last = 1'b1;
					packed_bytes_due.push_back(b);
				end
				held_bits = '0;
				held_count = '0;
			end
			default: ;
		endcase
	endtask

	task automatic queue_item(logic [1:0] kind, int sym, int code, int len, int pad);
		sym_item_t it;
		it.kind = kind;
		it.symbol = 8'(sym);
		it.code_bits = CODE_W'(code);
		it.code_length = LEN_W'(len);
		it.pad_shift = PAD_W'(pad);
		if (kind == KIND_LOAD && !entry_loaded[sym[7:0]]) begin
			entry_loaded[sym[7:0]] = 1'b1;
			loaded_symbols.push_back(sym[7:0]);
		end
		symbols_to_send.push_back(it);
		symbols_queued++;
	endtask

	task automatic queue_random_load();
		int r;
		int len;
		r = $urandom_range(0, 9);
		if (r == 0)
			len = $urandom_range(17, 31);
		else if (r == 1)
			len = 0;
		else
			len = $urandom_range(1, 16);
		queue_item(KIND_LOAD, $urandom_range(0, 255), $urandom_range(0, 65535), len,
			$urandom_range(0, 15));
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!sym_valid || sym_done) begin
				sym_done = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
					sym_valid <= 1'b0;
				end else if (symbols_to_send.size() != 0) begin
					sym_item <= symbols_to_send.pop_front();
					sym_valid <= 1'b1;
					send_gap = idle_draw(send_quiet);
				end else begin
					sym_valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (take_hold > 0) begin
			take_hold--;
			byte_stall <= 1'b1;
		end else begin
			byte_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		byte_item_t want;
		bit         moved;
		moved = 1'b0;
		if (arst_n) begin
			if (byte_valid === 1'b1 && byte_stall === 1'b0) begin
				moved = 1'b1;
				take_hold = idle_draw(take_quiet);
				if (packed_bytes_due.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %h last %b",
						byte_item.out_byte, byte_item.last));
				end else begin
					want = packed_bytes_due.pop_front();
					if (byte_item.out_byte !== want.out_byte)
						report_mismatch($sformatf("out_byte %h, expected %h",
							byte_item.out_byte, want.out_byte));
					if (byte_item.last !== want.last)
						report_mismatch($sformatf("last %b, expected %b",
							byte_item.last, want.last));
				end
			end
			if (sym_valid && sym_stall === 1'b0) begin
				moved = 1'b1;
				sym_done = 1'b1;
				symbols_taken++;
				pack_item(sym_item);
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout after %0d idle cycles", idle_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int r;
		held_bits = '0;
		held_count = '0;
		foreach (table_len[i]) begin
			table_len[i] = '0;
			table_code[i] = '0;
		end

		// Extremes of length, stray code bits and clamped lengths first.
		queue_item(KIND_LOAD, 0, 16'h0000, 0, 0);
		queue_item(KIND_LOAD, 255, 16'hFFFF, 16, 0);
		queue_item(KIND_LOAD, 1, 16'hFFFF, 3, 0);
		queue_item(KIND_LOAD, 2, 16'hA5A5, 31, 0);
		queue_item(KIND_LOAD, 3, 16'h0001, 1, 0);
		queue_item(KIND_LOAD, 4, 16'h005A, 8, 0);
		queue_item(KIND_LOAD, 5, 16'h02AB, 17, 0);
		queue_item(KIND_ENCODE, 255, 0, 0, 0);
		queue_item(KIND_ENCODE, 3, 0, 0, 0);
		queue_item(KIND_FLUSH, 0, 0, 0, 7);
		queue_item(KIND_ENCODE, 3, 0, 0, 0);
		queue_item(KIND_ENCODE, 1, 0, 0, 0);
		queue_item(KIND_FLUSH, 0, 0, 0, 15);
		queue_item(KIND_FLUSH, 0, 0, 0, 4);
		queue_item(KIND_ENCODE, 0, 0, 0, 0);
		queue_item(KIND_UNUSED, 255, 16'hFFFF, 31, 15);
		queue_item(KIND_ENCODE, 1, 0, 0, 0);
		queue_item(KIND_ENCODE, 255, 0, 0, 0);
		queue_item(KIND_ENCODE, 4, 0, 0, 0);
		queue_item(KIND_ENCODE, 2, 0, 0, 0);
		queue_item(KIND_ENCODE, 5, 0, 0, 0);
		queue_item(KIND_FLUSH, 0, 0, 0, 0);
		queue_item(KIND_ENCODE, 3, 0, 0, 0);
		queue_item(KIND_FLUSH, 0, 0, 0, 8);

		repeat (24) queue_random_load();
		repeat (RANDOM_ITEMS - 24) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				queue_item(KIND_ENCODE,
					loaded_symbols[$urandom_range(0, loaded_symbols.size() - 1)],
					$urandom_range(0, 65535), $urandom_range(0, 31), $urandom_range(0, 15));
			else if (r < 82)
				queue_random_load();
			else if (r < 96)
				queue_item(KIND_FLUSH, $urandom_range(0, 255), $urandom_range(0, 65535),
					$urandom_range(0, 31), $urandom_range(0, 15));
			else
				queue_item(KIND_UNUSED, $urandom_range(0, 255), $urandom_range(0, 65535),
					$urandom_range(0, 31), $urandom_range(0, 15));
		end

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (symbols_taken < symbols_queued)
			@(negedge clk);
		while (packed_bytes_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (packed_bytes_due.size() != 0)
			report_mismatch($sformatf("%0d bytes never arrived", packed_bytes_due.size()));

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
